// ===== rtl/fcc_pkg.sv =====
package fcc_pkg;

    localparam int unsigned FOOTER_BYTES  = 43;
    localparam int unsigned COVERED_BYTES = 39;
    localparam int unsigned COUNT_CAP     = 44;
    localparam int unsigned POS_W         = 6;
    localparam int unsigned QUEUE_DEPTH   = 4;
    localparam int unsigned CFG_ADDR_W    = 4;
    localparam int unsigned CFG_DATA_W    = 32;

    localparam logic [31:0] CRC_POLY   = 32'h82F6_3B78;
    localparam logic [31:0] CRC_PRESET = 32'hFFFF_FFFF;

    localparam logic [CFG_ADDR_W-1:0] CFG_MAGIC   = 4'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_VERSION = 4'd1;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_LEN   = 3'd1,
        ST_BAD_MAGIC = 3'd2,
        ST_BAD_VER   = 3'd3,
        ST_BAD_SIZE  = 3'd4,
        ST_BAD_CRC   = 3'd5
    } status_t;

    // one classified byte on its way from front to back
    typedef struct packed {
        logic [7:0]       data;
        logic [POS_W-1:0] pos;
        logic             last;
    } fcc_item_t;

    function automatic logic [31:0] crc32c_byte(input logic [31:0] crc_in,
                                                input logic [7:0]  b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== rtl/fcc_front.sv =====
module fcc_front
    import fcc_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // [7:0] data_byte
    input  logic             s_tlast,
    input  logic             q_full,
    output logic             q_push,
    output fcc_item_t        q_item
);

    logic [POS_W-1:0] byte_count_reg, byte_count_next;

    assign s_tready    = !q_full;
    assign q_push      = s_tvalid && s_tready;
    assign q_item.data = s_tdata;
    assign q_item.pos  = byte_count_reg;
    assign q_item.last = s_tlast;

    always_comb begin
        byte_count_next = byte_count_reg;
        if (q_push) begin
            if (s_tlast) begin
                byte_count_next = '0;
            end else if (byte_count_reg < POS_W'(COUNT_CAP)) begin
                byte_count_next = byte_count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg <= '0;
        end else begin
            byte_count_reg <= byte_count_next;
        end
    end

endmodule

// ===== rtl/fcc_queue.sv =====
module fcc_queue
    import fcc_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  fcc_item_t push_item,
    output logic      full,
    input  logic      pop,
    output logic      pop_valid,
    output fcc_item_t pop_item
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    fcc_item_t        mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_item  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (count_reg != CNT_W'(DEPTH)))
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (count_reg != '0))
        else $error("pop from empty queue");
    a_count_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count lost a push");

endmodule

// ===== rtl/fcc_back.sv =====
module fcc_back
    import fcc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    input  fcc_item_t   q_item,
    output logic        q_pop,
    input  logic [31:0] expected_magic,
    input  logic [15:0] expected_version,
    output logic        m_valid,
    input  logic        m_ready,
    output status_t     m_status,
    output logic [63:0] m_region_offset,
    output logic [63:0] m_region_length,
    output logic [63:0] m_hot_offset,
    output logic [31:0] m_region_checksum,
    output logic [31:0] m_header_checksum
);

    logic [31:0] crc_reg, crc_next;
    logic [31:0] magic_reg, magic_next;
    logic [15:0] version_reg, version_next;
    logic [63:0] offset_reg, offset_next;
    logic [63:0] length_reg, length_next;
    logic [63:0] hot_reg, hot_next;
    logic [31:0] rcrc_reg, rcrc_next;
    logic [31:0] hcrc_reg, hcrc_next;
    logic [7:0]  size_reg, size_next;
    logic [31:0] stored_reg, stored_next;

    logic        m_valid_reg, m_valid_next;
    status_t     status_reg, status_next;
    logic [63:0] out_offset_reg, out_length_reg, out_hot_reg;
    logic [31:0] out_rcrc_reg, out_hcrc_reg;

    logic [POS_W-1:0] pos;
    logic [7:0]       b;
    logic [2:0]       lane64;
    logic [1:0]       lane32;
    logic [1:0]       lane_crc;
    logic             finish;

    // a closing item may only retire once the output register is free
    assign q_pop  = q_valid && (!q_item.last || !m_valid_reg || m_ready);
    assign finish = q_pop && q_item.last;

    assign pos      = q_item.pos;
    assign b        = q_item.data;
    assign lane64   = pos[2:0] - 3'd6;
    assign lane32   = pos[1:0] - 2'd2;
    assign lane_crc = pos[1:0] - 2'd3;

    always_comb begin
        crc_next     = crc_reg;
        magic_next   = magic_reg;
        version_next = version_reg;
        offset_next  = offset_reg;
        length_next  = length_reg;
        hot_next     = hot_reg;
        rcrc_next    = rcrc_reg;
        hcrc_next    = hcrc_reg;
        size_next    = size_reg;
        stored_next  = stored_reg;
        if (q_pop) begin
            if (pos < POS_W'(4)) begin
                magic_next[8*pos[1:0] +: 8] = b;
            end else if (pos < POS_W'(6)) begin
                version_next[8*pos[0] +: 8] = b;
            end else if (pos < POS_W'(14)) begin
                offset_next[8*lane64 +: 8] = b;
            end else if (pos < POS_W'(22)) begin
                length_next[8*lane64 +: 8] = b;
            end else if (pos < POS_W'(30)) begin
                hot_next[8*lane64 +: 8] = b;
            end else if (pos < POS_W'(34)) begin
                rcrc_next[8*lane32 +: 8] = b;
            end else if (pos < POS_W'(38)) begin
                hcrc_next[8*lane32 +: 8] = b;
            end else if (pos < POS_W'(COVERED_BYTES)) begin
                size_next = b;
            end else if (pos < POS_W'(FOOTER_BYTES)) begin
                stored_next[8*lane_crc +: 8] = b;
            end
            if (pos < POS_W'(COVERED_BYTES)) begin
                crc_next = crc32c_byte(crc_reg, b);
            end
        end
    end

    always_comb begin
        // the count after this byte is the footer length only at the final position
        if (pos != POS_W'(FOOTER_BYTES - 1)) begin
            status_next = ST_BAD_LEN;
        end else if (magic_next != expected_magic) begin
            status_next = ST_BAD_MAGIC;
        end else if (version_next != expected_version) begin
            status_next = ST_BAD_VER;
        end else if (size_next != 8'(FOOTER_BYTES)) begin
            status_next = ST_BAD_SIZE;
        end else if (stored_next != ~crc_next) begin
            status_next = ST_BAD_CRC;
        end else begin
            status_next = ST_OK;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (finish) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || finish) begin
            crc_reg     <= CRC_PRESET;
            magic_reg   <= '0;
            version_reg <= '0;
            offset_reg  <= '0;
            length_reg  <= '0;
            hot_reg     <= '0;
            rcrc_reg    <= '0;
            hcrc_reg    <= '0;
            size_reg    <= '0;
            stored_reg  <= '0;
        end else begin
            crc_reg     <= crc_next;
            magic_reg   <= magic_next;
            version_reg <= version_next;
            offset_reg  <= offset_next;
            length_reg  <= length_next;
            hot_reg     <= hot_next;
            rcrc_reg    <= rcrc_next;
            hcrc_reg    <= hcrc_next;
            size_reg    <= size_next;
            stored_reg  <= stored_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (finish) begin
            status_reg     <= status_next;
            out_offset_reg <= offset_next;
            out_length_reg <= length_next;
            out_hot_reg    <= hot_next;
            out_rcrc_reg   <= rcrc_next;
            out_hcrc_reg   <= hcrc_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = status_reg;
    assign m_region_offset   = out_offset_reg;
    assign m_region_length   = out_length_reg;
    assign m_hot_offset      = out_hot_reg;
    assign m_region_checksum = out_rcrc_reg;
    assign m_header_checksum = out_hcrc_reg;

    a_hold_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_valid && q_item.last && m_valid_reg && !m_ready) |-> !q_pop)
        else $error("closing item retired over a pending result");
    a_clear_after: assert property (@(posedge aclk) disable iff (!aresetn)
        finish |=> (crc_reg == CRC_PRESET && size_reg == '0 && stored_reg == '0))
        else $error("state not cleared after closing item");
    a_result_set: assert property (@(posedge aclk) disable iff (!aresetn)
        finish |=> m_valid_reg)
        else $error("closing item produced no result");

endmodule

// ===== rtl/fixed_footer_crc32c_checker.sv =====
// Channel  Dir  Handshake             Payload
// s_       in   s_tvalid/s_tready     tdata: data_byte; tlast: last_byte
// m_       out  m_tvalid/m_tready     tdata: offsets, length, checksums; tuser: status
// cfg_     in   cfg_wr_en             cfg_addr selects magic or version, cfg_wdata value
//
// One byte per cycle is accepted while the queue is not full; the back end applies
// the CRC-32C byte update and field placement to each byte. Bytes pass through the
// queue to the back end, and a result shows in the cycle after its closing byte is
// taken from the queue. Reset is synchronous and active low.
// A stalled result holds only closing bytes; the queue keeps accepting until full.
module fixed_footer_crc32c_checker
    import fcc_pkg::*;
#(
    parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] data_byte
    input  logic                  s_tlast,   // last_byte
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [63:0] region_offset, [127:64] region_length, [191:128] hot_offset,
    // [223:192] region_checksum, [255:224] header_checksum
    output logic [255:0]          m_tdata,
    output logic [7:0]            m_tuser,   // [2:0] status, [7:3] zero
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic [31:0] exp_magic_reg;
    logic [15:0] exp_version_reg;

    logic      q_full, q_push, q_pop, q_valid;
    fcc_item_t push_item, pop_item;
    status_t   status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_magic_reg   <= '0;
            exp_version_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_MAGIC:   exp_magic_reg   <= cfg_wdata;
                CFG_VERSION: exp_version_reg <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    fcc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    fcc_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_item  (pop_item)
    );

    fcc_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .q_valid           (q_valid),
        .q_item            (pop_item),
        .q_pop             (q_pop),
        .expected_magic    (exp_magic_reg),
        .expected_version  (exp_version_reg),
        .m_valid           (m_tvalid),
        .m_ready           (m_tready),
        .m_status          (status),
        .m_region_offset   (m_tdata[63:0]),
        .m_region_length   (m_tdata[127:64]),
        .m_hot_offset      (m_tdata[191:128]),
        .m_region_checksum (m_tdata[223:192]),
        .m_header_checksum (m_tdata[255:224])
    );

    assign m_tuser = {5'd0, status};

endmodule
